/* design/abts_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// abts_pkg
// Shared types and constants of the array-based binary tree store.
// ============================================================================
package abts_pkg;

    // Default sizes of the store.
    localparam int SLOT_COUNT_DEF = 128;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the request and result words.
    localparam int ACTION_W    = 3;
    localparam int SLOT_IDX_W  = 7;
    localparam int NODE_DATA_W = 32;
    localparam int VALUE_W     = 32;

    // Width for slot arithmetic: a grandchild of the largest addressable
    // slot, 2 * (2 * 127 + 2) + 2, still fits.
    localparam int IDX_CALC_W = 11;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ROOT   = 3'd0,
        ACT_LEFT   = 3'd1,
        ACT_RIGHT  = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_QUERY  = 3'd4
    } action_t;

    typedef struct packed {
        logic               done_res;
        logic               slot_present;
        logic [VALUE_W-1:0] slot_value;
        logic               slot_is_leaf;
        logic               tree_empty;
    } res_t;

endpackage

/* design/abts_ifs.sv */
`timescale 1ns / 1ps
// ============================================================================
// abts_in_if / abts_out_if
// Valid/ready channels for request words and result words.
// ============================================================================
interface abts_in_if import abts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [SLOT_IDX_W-1:0]  slot_index;
    logic [NODE_DATA_W-1:0] node_data;

    modport source (output valid, output action, output slot_index, output node_data,
                    input ready);
    modport sink   (input valid, input action, input slot_index, input node_data,
                    output ready);
endinterface

interface abts_out_if import abts_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               done_res;
    logic               slot_present;
    logic [VALUE_W-1:0] slot_value;
    logic               slot_is_leaf;
    logic               tree_empty;

    modport source (output valid, output done_res, output slot_present, output slot_value,
                    output slot_is_leaf, output tree_empty, input ready);
    modport sink   (input valid, input done_res, input slot_present, input slot_value,
                    input slot_is_leaf, input tree_empty, output ready);
endinterface

/* design/abts_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// abts_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module abts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/abts_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// abts_ctrl
// Request sequencer: clears the presence bits after reset, reads the parent,
// the reported slot and its two children, then writes back and reports.
// ============================================================================
module abts_ctrl import abts_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = $clog2(SLOT_COUNT)
) (
    input  logic                clk,
    input  logic                rst_n,
    abts_in_if.sink             in_ch,
    output logic                res_valid,
    input  logic                res_ready,
    output res_t                res,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic [DATA_WIDTH:0] mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    input  logic [DATA_WIDTH:0] mem_rdata
);

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_RD   = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_UPD  = 5'b10000
    } state_t;

    localparam logic [1:0] RD_PARENT = 2'd0;
    localparam logic [1:0] RD_SLOT   = 2'd1;
    localparam logic [1:0] RD_LEFT   = 2'd2;
    localparam logic [1:0] RD_RIGHT  = 2'd3;

    state_t                  state_reg, state_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                    root_reg, root_next;
    logic                    cap_vld_reg, cap_vld_next;
    logic [1:0]              cap_k_reg, cap_k_next;
    logic                    cap_ok_reg, cap_ok_next;
    logic                    pv_reg, sv_reg, c1v_reg, c2v_reg;

    logic [ACTION_W-1:0]     act_reg;
    logic [IDX_CALC_W-1:0]   p_reg, s_reg;
    logic                    s_ok_reg;
    logic [DATA_WIDTH-1:0]   data_reg, sval_reg;

    logic                    accept;
    logic [IDX_CALC_W-1:0]   in_base, in_shown, rd_addr;
    logic                    rd_ok, rd_bit, no_kids, leaf_now;
    logic                    u_we, root_after;
    logic [DATA_WIDTH:0]     u_wdata;
    logic                    u_done, u_present, u_leaf;
    logic [DATA_WIDTH-1:0]   u_value;

    assign accept      = (state_reg == ST_IDLE) && in_ch.valid;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // The reported slot: the root, the child 2i+1 or 2i+2, or the index itself.
    assign in_base = IDX_CALC_W'(in_ch.slot_index);
    always_comb
    begin
        case (in_ch.action) inside
            ACT_ROOT:           in_shown = '0;
            ACT_LEFT, ACT_RIGHT: in_shown = (in_base << 1) + IDX_CALC_W'(in_ch.action);
            default:            in_shown = in_base;
        endcase
    end

    always_comb
    begin
        case (cnt_reg)
            RD_PARENT: rd_addr = p_reg;
            RD_SLOT:   rd_addr = s_reg;
            RD_LEFT:   rd_addr = (s_reg << 1) + IDX_CALC_W'(1);
            default:   rd_addr = (s_reg << 1) + IDX_CALC_W'(2);
        endcase
    end

    // Slots beyond the store read as absent.
    assign rd_ok  = 32'(rd_addr) < 32'(SLOT_COUNT);
    assign rd_bit = mem_rdata[DATA_WIDTH] && cap_ok_reg;

    assign no_kids  = !c1v_reg && !c2v_reg;
    assign leaf_now = sv_reg && no_kids;

    always_comb
    begin
        u_we       = 1'b0;
        u_wdata    = {1'b1, data_reg};
        u_done     = 1'b0;
        u_present  = sv_reg;
        u_value    = sv_reg ? sval_reg : '0;
        u_leaf     = leaf_now;
        root_after = root_reg;
        case (act_reg) inside
            ACT_ROOT:
            begin
                u_we       = 1'b1;
                u_done     = 1'b1;
                u_present  = 1'b1;
                u_value    = data_reg;
                u_leaf     = no_kids;
                root_after = 1'b1;
            end
            ACT_LEFT, ACT_RIGHT:
            begin
                if (pv_reg && s_ok_reg)
                begin
                    u_we      = 1'b1;
                    u_done    = 1'b1;
                    u_present = 1'b1;
                    u_value   = data_reg;
                    u_leaf    = no_kids;
                end
            end
            ACT_REMOVE:
            begin
                if (leaf_now)
                begin
                    u_we      = 1'b1;
                    u_wdata   = {1'b0, sval_reg};
                    u_done    = 1'b1;
                    u_present = 1'b0;
                    u_value   = '0;
                    u_leaf    = 1'b0;
                    if (s_reg == '0)
                    begin
                        root_after = 1'b0;
                    end
                end
            end
            ACT_QUERY:
            begin
                u_done = sv_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid         = (state_reg == ST_UPD);
    assign res.done_res      = u_done;
    assign res.slot_present  = u_present;
    assign res.slot_value    = VALUE_W'(u_value);
    assign res.slot_is_leaf  = u_leaf;
    assign res.tree_empty    = !root_after;

    assign mem_we    = (state_reg == ST_CLR) || (res_valid && res_ready && u_we);
    assign mem_waddr = (state_reg == ST_CLR) ? clr_cnt_reg : AW'(s_reg);
    assign mem_wdata = (state_reg == ST_CLR) ? '0 : u_wdata;
    assign mem_raddr = AW'(rd_addr);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        root_next    = root_reg;
        cap_vld_next = (state_reg == ST_RD);
        cap_k_next   = cnt_reg;
        cap_ok_next  = rd_ok;
        unique case (state_reg)
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = RD_PARENT;
                if (in_ch.valid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == RD_RIGHT)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (res_ready)
                begin
                    root_next  = root_after;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            cnt_reg     <= RD_PARENT;
            clr_cnt_reg <= '0;
            root_reg    <= 1'b0;
            cap_vld_reg <= 1'b0;
            cap_k_reg   <= RD_PARENT;
            cap_ok_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_cnt_reg <= clr_cnt_next;
            root_reg    <= root_next;
            cap_vld_reg <= cap_vld_next;
            cap_k_reg   <= cap_k_next;
            cap_ok_reg  <= cap_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= in_ch.action;
            p_reg    <= in_base;
            s_reg    <= in_shown;
            s_ok_reg <= 32'(in_shown) < 32'(SLOT_COUNT);
            data_reg <= DATA_WIDTH'(in_ch.node_data);
        end
        if (cap_vld_reg)
        begin
            case (cap_k_reg)
                RD_PARENT: pv_reg <= rd_bit;
                RD_SLOT:
                begin
                    sv_reg   <= rd_bit;
                    sval_reg <= mem_rdata[DATA_WIDTH-1:0];
                end
                RD_LEFT:   c1v_reg <= rd_bit;
                default:   c2v_reg <= rd_bit;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_UPD) |-> s_ok_reg)
        else $error("write-back addresses a slot beyond the store");

    a_root_insert_sets_root: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && act_reg == ACT_ROOT) |=> root_reg)
        else $error("root insert did not mark the root present");

    a_root_remove_clears_root: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && act_reg == ACT_REMOVE && res.done_res && s_reg == '0)
        |=> !root_reg)
        else $error("root removal left the root present");

    a_update_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> ($past(state_reg) == ST_WAIT || $past(state_reg) == ST_UPD))
        else $error("update entered without completing the slot reads");
`endif

endmodule

/* design/array_binary_tree_store_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// array_binary_tree_store_top
// Binary tree kept in an implicit array of slots, one request at a time.
// ============================================================================
// After reset the block sweeps the slot memory once to clear every presence
// bit, with in.ready low. The slot memory has one read port, and a request
// reads four entries (parent, reported slot and its two children) before it
// writes back and hands its result word to the output register; the next
// request is taken in only after that. A finished result waits in that
// register while the next request is taken in.
module array_binary_tree_store_top import abts_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    abts_in_if.sink    in_ch,
    abts_out_if.source out_ch
);

    localparam int AW = $clog2(SLOT_COUNT);

    logic                res_valid, res_ready;
    res_t                res;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [DATA_WIDTH:0] mem_wdata, mem_rdata;

    logic                out_valid_reg, out_valid_next;
    res_t                out_word_reg;

    abts_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Each entry holds the presence bit above the stored value.
    abts_ram #(
        .WIDTH (DATA_WIDTH + 1),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_word_reg <= res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.done_res     = out_word_reg.done_res;
    assign out_ch.slot_present = out_word_reg.slot_present;
    assign out_ch.slot_value   = out_word_reg.slot_value;
    assign out_ch.slot_is_leaf = out_word_reg.slot_is_leaf;
    assign out_ch.tree_empty   = out_word_reg.tree_empty;

endmodule
